// File: src/yfr_pkg.sv
`timescale 1ns / 1ps
// types and constants shared by the yuy2 frame rotation block
package yfr_pkg;

    localparam int unsigned MODE_W      = 2;
    localparam int unsigned ROW_BYTES_W = 14;
    localparam int unsigned HEIGHT_W    = 13;
    localparam int unsigned PITCH_W     = 15;
    localparam int unsigned COL_W       = 11;
    localparam int unsigned ROW_W       = 12;
    localparam int unsigned OFF_W       = 26;
    localparam int unsigned PIX_W       = 8;
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 15;

    localparam int unsigned MAX_ROW_BYTES = 8192;
    localparam int unsigned MAX_HEIGHT    = 4096;

    localparam logic [MODE_W-1:0] TURN_LEFT  = 2'd0;
    localparam logic [MODE_W-1:0] TURN_RIGHT = 2'd1;
    localparam logic [MODE_W-1:0] TURN_HALF  = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] REG_TURN_MODE    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ROW_BYTES    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_DEST_PITCH   = 2'd3;

    localparam logic [ROW_BYTES_W-1:0] RESET_ROW_BYTES    = 14'd4;
    localparam logic [HEIGHT_W-1:0]    RESET_FRAME_HEIGHT = 13'd2;
    localparam logic [PITCH_W-1:0]     RESET_DEST_PITCH   = 15'd4;

    typedef struct packed {
        logic [MODE_W-1:0]      turn_mode;
        logic [ROW_BYTES_W-1:0] row_bytes;
        logic [HEIGHT_W-1:0]    frame_height;
        logic [PITCH_W-1:0]     dest_pitch;
    } cfg_t;

    typedef struct packed {
        logic [COL_W-1:0] column;
        logic [ROW_W-1:0] row;
        logic [PIX_W-1:0] top_luma0;
        logic [PIX_W-1:0] top_chroma_u;
        logic [PIX_W-1:0] top_luma1;
        logic [PIX_W-1:0] top_chroma_v;
        logic [PIX_W-1:0] bottom_luma0;
        logic [PIX_W-1:0] bottom_chroma_u;
        logic [PIX_W-1:0] bottom_luma1;
        logic [PIX_W-1:0] bottom_chroma_v;
    } item_t;

    typedef struct packed {
        logic [OFF_W-1:0] offset;
        logic [PIX_W-1:0] byte0;
        logic [PIX_W-1:0] byte1;
        logic [PIX_W-1:0] byte2;
        logic [PIX_W-1:0] byte3;
    } word_t;

    typedef struct packed {
        word_t word0;
        word_t word1;
        logic  two_words;
    } result_t;

endpackage

// File: src/yuy2_frame_rotate.sv
`timescale 1ns / 1ps
// yuy2 frame rotation: quarter turns left or right and half turn of macropixels
// an accepted item waits in the input register until the result register is free
// throughput: half turn one item per cycle while out_ready is high; quarter turns
//   take a new item only after both destination words pass, one per transaction
// reset: asynchronous active-low rst_n empties both register stages and restores
//   the configuration to half turn, row_bytes 4, frame_height 2, dest_pitch 4
module yuy2_frame_rotate (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [14:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [10:0] column,
    input  logic [11:0] row,
    input  logic [7:0]  top_luma0,
    input  logic [7:0]  top_chroma_u,
    input  logic [7:0]  top_luma1,
    input  logic [7:0]  top_chroma_v,
    input  logic [7:0]  bottom_luma0,
    input  logic [7:0]  bottom_chroma_u,
    input  logic [7:0]  bottom_luma1,
    input  logic [7:0]  bottom_chroma_v,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [25:0] dest_offset,
    output logic [7:0]  out_byte0,
    output logic [7:0]  out_byte1,
    output logic [7:0]  out_byte2,
    output logic [7:0]  out_byte3,
    output logic        last_of_item
);
    import yfr_pkg::*;

    cfg_t    cfg;
    item_t   item_reg;
    logic    in_valid_reg;
    logic    in_valid_next;
    logic    load;
    logic    res_free;
    logic    in_take;
    result_t result;

    yfr_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    always_comb
    begin
        load          = in_valid_reg && res_free;
        in_ready      = !in_valid_reg || load;
        in_take       = in_valid && in_ready;
        in_valid_next = in_take ? 1'b1 : (load ? 1'b0 : in_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg.column          <= column;
            item_reg.row             <= row;
            item_reg.top_luma0       <= top_luma0;
            item_reg.top_chroma_u    <= top_chroma_u;
            item_reg.top_luma1       <= top_luma1;
            item_reg.top_chroma_v    <= top_chroma_v;
            item_reg.bottom_luma0    <= bottom_luma0;
            item_reg.bottom_chroma_u <= bottom_chroma_u;
            item_reg.bottom_luma1    <= bottom_luma1;
            item_reg.bottom_chroma_v <= bottom_chroma_v;
        end
    end

    yfr_calc u_calc (
        .cfg    (cfg),
        .item   (item_reg),
        .result (result)
    );

    yfr_out u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (load),
        .result       (result),
        .free         (res_free),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .dest_offset  (dest_offset),
        .out_byte0    (out_byte0),
        .out_byte1    (out_byte1),
        .out_byte2    (out_byte2),
        .out_byte3    (out_byte3),
        .last_of_item (last_of_item)
    );

endmodule

// File: src/yfr_cfg.sv
`timescale 1ns / 1ps
// configuration registers with width masking and size saturation
module yfr_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [yfr_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [yfr_pkg::CFG_DATA_W-1:0]   cfg_data,
    output yfr_pkg::cfg_t                    cfg
);
    import yfr_pkg::*;

    cfg_t                   cfg_reg;
    cfg_t                   cfg_next;
    logic [ROW_BYTES_W-1:0] rb_in;
    logic [HEIGHT_W-1:0]    fh_in;

    always_comb
    begin
        rb_in    = cfg_data[ROW_BYTES_W-1:0];
        fh_in    = cfg_data[HEIGHT_W-1:0];
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_TURN_MODE:    cfg_next.turn_mode = cfg_data[MODE_W-1:0];
                REG_ROW_BYTES:
                begin
                    if (rb_in > ROW_BYTES_W'(MAX_ROW_BYTES))
                        cfg_next.row_bytes = ROW_BYTES_W'(MAX_ROW_BYTES);
                    else
                        cfg_next.row_bytes = rb_in;
                end
                REG_FRAME_HEIGHT:
                begin
                    if (fh_in > HEIGHT_W'(MAX_HEIGHT))
                        cfg_next.frame_height = HEIGHT_W'(MAX_HEIGHT);
                    else
                        cfg_next.frame_height = fh_in;
                end
                REG_DEST_PITCH:   cfg_next.dest_pitch = cfg_data[PITCH_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.turn_mode    <= TURN_HALF;
            cfg_reg.row_bytes    <= RESET_ROW_BYTES;
            cfg_reg.frame_height <= RESET_FRAME_HEIGHT;
            cfg_reg.dest_pitch   <= RESET_DEST_PITCH;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: src/yfr_calc.sv
`timescale 1ns / 1ps
// destination offsets, byte order and rounded chroma averages for one macropixel item
module yfr_calc (
    input  yfr_pkg::cfg_t    cfg,
    input  yfr_pkg::item_t   item,
    output yfr_pkg::result_t result
);
    import yfr_pkg::*;

    logic                     is_left;
    logic                     is_right;
    logic                     quarter;
    logic [OFF_W-1:0]         col_x;
    logic [OFF_W-1:0]         row_x;
    logic [OFF_W-1:0]         height_x;
    logic [OFF_W-1:0]         width_x;
    logic [OFF_W-1:0]         pitch_x;
    logic [OFF_W-1:0]         col_back;
    logic [OFF_W-1:0]         right_base;
    logic [OFF_W-1:0]         half_row;
    logic [OFF_W-1:0]         mult_a;
    logic [OFF_W+PITCH_W-1:0] prod_full;
    logic [OFF_W-1:0]         prod_s;
    logic [OFF_W-1:0]         addend;
    logic [OFF_W-1:0]         addend_p;
    logic [PIX_W:0]           u_sum;
    logic [PIX_W:0]           v_sum;
    logic [PIX_W-1:0]         u_avg;
    logic [PIX_W-1:0]         v_avg;

    always_comb
    begin
        is_right = (cfg.turn_mode == TURN_RIGHT);
        is_left  = (cfg.turn_mode == TURN_LEFT);
        quarter  = is_right || is_left;

        col_x    = OFF_W'(item.column);
        row_x    = OFF_W'(item.row);
        height_x = OFF_W'(cfg.frame_height);
        width_x  = OFF_W'(cfg.row_bytes[ROW_BYTES_W-1:2]);
        pitch_x  = OFF_W'(cfg.dest_pitch);

        col_back   = width_x - OFF_W'(1) - col_x;
        right_base = height_x - OFF_W'(2) - row_x;
        half_row   = height_x - OFF_W'(1) - row_x;

        if (is_right)
        begin
            mult_a = col_x;
            addend = right_base << 1;
        end
        else if (is_left)
        begin
            mult_a = col_back;
            addend = row_x << 1;
        end
        else
        begin
            mult_a = half_row;
            addend = col_back << 2;
        end

        prod_full = mult_a * cfg.dest_pitch;
        prod_s    = quarter ? (prod_full[OFF_W-1:0] << 1) : prod_full[OFF_W-1:0];
        addend_p  = addend + pitch_x;

        u_sum = {1'b0, item.top_chroma_u} + {1'b0, item.bottom_chroma_u} + (PIX_W+1)'(1);
        v_sum = {1'b0, item.top_chroma_v} + {1'b0, item.bottom_chroma_v} + (PIX_W+1)'(1);
        u_avg = u_sum[PIX_W:1];
        v_avg = v_sum[PIX_W:1];

        result.two_words     = quarter;
        result.word0.offset  = prod_s + addend;
        result.word1.offset  = prod_s + addend_p;
        result.word0.byte1   = u_avg;
        result.word0.byte3   = v_avg;
        result.word1.byte1   = u_avg;
        result.word1.byte3   = v_avg;
        result.word1.byte0   = item.top_luma0;
        result.word1.byte2   = item.bottom_luma0;

        if (is_right)
        begin
            result.word0.byte0 = item.bottom_luma0;
            result.word0.byte2 = item.top_luma0;
            result.word1.byte0 = item.bottom_luma1;
            result.word1.byte2 = item.top_luma1;
        end
        else if (is_left)
        begin
            result.word0.byte0 = item.top_luma1;
            result.word0.byte2 = item.bottom_luma1;
        end
        else
        begin
            result.word0.byte0 = item.top_luma1;
            result.word0.byte1 = item.top_chroma_u;
            result.word0.byte2 = item.top_luma0;
            result.word0.byte3 = item.top_chroma_v;
        end
    end

endmodule

// File: src/yfr_out.sv
`timescale 1ns / 1ps
// result register and word sequencer for the output channel
module yfr_out (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        load,
    input  yfr_pkg::result_t            result,
    output logic                        free,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [yfr_pkg::OFF_W-1:0]   dest_offset,
    output logic [yfr_pkg::PIX_W-1:0]   out_byte0,
    output logic [yfr_pkg::PIX_W-1:0]   out_byte1,
    output logic [yfr_pkg::PIX_W-1:0]   out_byte2,
    output logic [yfr_pkg::PIX_W-1:0]   out_byte3,
    output logic                        last_of_item
);
    import yfr_pkg::*;

    result_t res_reg;
    logic    valid_reg;
    logic    valid_next;
    logic    sel_reg;
    logic    sel_next;
    logic    last;
    logic    taken;
    word_t   word;

    always_comb
    begin
        last  = !res_reg.two_words || sel_reg;
        taken = valid_reg && out_ready;
        free  = !valid_reg || (taken && last);

        valid_next = valid_reg;
        sel_next   = sel_reg;
        if (load)
        begin
            valid_next = 1'b1;
            sel_next   = 1'b0;
        end
        else if (taken)
        begin
            if (last)
                valid_next = 1'b0;
            else
                sel_next = 1'b1;
        end

        word = sel_reg ? res_reg.word1 : res_reg.word0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            sel_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            sel_reg   <= sel_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= result;
    end

    assign out_valid    = valid_reg;
    assign dest_offset  = word.offset;
    assign out_byte0    = word.byte0;
    assign out_byte1    = word.byte1;
    assign out_byte2    = word.byte2;
    assign out_byte3    = word.byte3;
    assign last_of_item = last;

endmodule
